@@ rtl/mcts_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the multi-channel timed step sequencer.
// No dependencies; every other file imports this package.
package mcts_pkg;

    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_MAX_STEPS    = 16;
    localparam int STEP_W           = 5;
    localparam int CFG_W            = 4;
    localparam logic [STEP_W-1:0] STEP_SAT = '1;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_PLAY = 2'd1,
        OP_STOP = 2'd2,
        OP_LOAD = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_START  = 2'd1,
        KIND_STOP   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_WAITING = 2'd0,
        PH_ACTIVE  = 2'd1,
        PH_IDLE    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EX,
        ST_STOP,
        ST_RA_RD,
        ST_RA_EX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic [7:0]  finished_mask;
        logic [2:0]  load_channel;
        logic [3:0]  load_step;
        logic [15:0] step_delay_ms;
        logic [15:0] step_max_ms;
        logic [15:0] step_instruction;
        logic        step_is_final;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [2:0]  event_channel;
        logic [15:0] event_instruction;
        logic        busy_res;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [15:0] delay;
        logic [15:0] duration;
        logic [15:0] code;
    } tl_entry_t;

    // sequencer -> event queue
    typedef struct packed {
        logic        push;
        kind_t       kind;
        logic [2:0]  chan;
        logic [15:0] instr;
        logic        close;
        logic        busy;
    } evq_ctl_t;

endpackage

@@ rtl/multi_channel_timed_step_sequencer_top.sv @@
`timescale 1ns / 1ps
// Multi-channel timed step sequencer, top level. Uses mcts_pkg, mcts_tl_mem, mcts_evq.
// One word at a time (n = channels in use, k = events of the word). After the accepting
// edge a tick visits the n channels (none when stopped) and rearms and stops them all once
// none is busy; stop all pushes a stop per channel, then rearms; play rearms unless running.
// The per-channel visit, one timeline memory read plus one shared 32-bit add, sets the pace.
// The k+1 result words then load one per cycle while the output is not stalled; input is
// taken again the cycle after the status word is loaded.
// Reset (rst_n, async low) clears control and channel state; timeline memory is not cleared.
module multi_channel_timed_step_sequencer_top
    import mcts_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_STEPS    = DEF_MAX_STEPS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_word
);

    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DEPTH = MAX_CHANNELS * MAX_STEPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW:0] NCH = (CW+1)'(MAX_CHANNELS);

    // control
    state_t           state_reg, state_next;
    logic [CW:0]      ch_reg, ch_next;
    logic             running_reg, running_next;
    logic             run_after_reg, run_after_next;   // running value once rearm ends
    logic             busy_reg, busy_next;             // some channel still busy in tick
    logic             rd_ok_reg, rd_ok_next;           // step index was in range
    logic [CFG_W-1:0] cfg_reg;
    logic [31:0]      now_reg;
    logic [7:0]       fin_reg;

    // per-channel state
    phase_t              phase_reg [MAX_CHANNELS];
    logic [STEP_W-1:0]   step_reg  [MAX_CHANNELS];
    logic [31:0]         act_reg   [MAX_CHANNELS];
    logic [31:0]         end_reg   [MAX_CHANNELS];
    logic [STEP_W-1:0]   len_reg   [MAX_CHANNELS];

    logic [CW:0]       n_ch;
    logic [CW-1:0]     chi;
    logic              accept;
    logic              evq_busy;
    evq_ctl_t          ctl;

    // memory ports
    logic              mem_wr;
    logic [AW-1:0]     mem_waddr;
    logic              mem_rd;
    logic [AW-1:0]     mem_raddr;
    logic [STEP_W-1:0] rd_step;
    tl_entry_t         mem_q;

    // channel update from the visit
    logic              ch_we;
    phase_t            ph_new;
    logic [STEP_W-1:0] step_new;
    logic [STEP_W-1:0] step_inc;
    logic              act_we, end_we;
    logic [15:0]       opnd;
    logic [31:0]       sum;
    logic              load_ok;

    function automatic logic [CW:0] ch_w(input logic [CFG_W-1:0] v);
        ch_w = v[CW:0];
    endfunction

    assign n_ch   = (cfg_reg > CFG_W'(MAX_CHANNELS)) ? NCH : ch_w(cfg_reg);
    assign chi    = ch_reg[CW-1:0];
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || evq_busy;

    // saturating next step of the visited channel
    assign step_inc = (step_reg[chi] != STEP_SAT) ? step_reg[chi] + STEP_W'(1) : step_reg[chi];

    // shared adder: now plus a 16-bit timeline field
    assign sum = now_reg + {16'd0, opnd};

    assign load_ok = (32'(in_word.load_channel) < MAX_CHANNELS)
                  && (32'(in_word.load_step) < MAX_STEPS);
    assign mem_wr    = accept && (op_t'(in_word.op) == OP_LOAD) && load_ok;
    assign mem_waddr = AW'(32'(in_word.load_channel) * MAX_STEPS + 32'(in_word.load_step));

    mcts_tl_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (mem_waddr),
        .wr_data ('{delay: in_word.step_delay_ms, duration: in_word.step_max_ms,
                    code: in_word.step_instruction}),
        .rd_en   (mem_rd),
        .rd_addr (mem_raddr),
        .rd_data (mem_q)
    );

    mcts_evq u_evq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .busy      (evq_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        running_next   = running_reg;
        run_after_next = run_after_reg;
        busy_next      = busy_reg;
        rd_ok_next     = rd_ok_reg;
        ctl            = '{push: 1'b0, kind: KIND_STATUS, chan: 3'd0, instr: 16'd0,
                           close: 1'b0, busy: 1'b0};
        mem_rd         = 1'b0;
        rd_step        = '0;
        ch_we          = 1'b0;
        ph_new         = phase_reg[chi];
        step_new       = step_reg[chi];
        act_we         = 1'b0;
        end_we         = 1'b0;
        opnd           = 16'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ch_next   = '0;
                    busy_next = 1'b0;
                    unique case (op_t'(in_word.op))
                        OP_TICK:
                        begin
                            state_next = running_reg ? ST_RD : ST_OUT;
                        end
                        OP_PLAY:
                        begin
                            run_after_next = 1'b1;
                            state_next     = running_reg ? ST_OUT : ST_RA_RD;
                        end
                        OP_STOP:
                        begin
                            run_after_next = 1'b0;
                            state_next     = ST_STOP;
                        end
                        OP_LOAD:
                        begin
                            state_next = ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_RD:
            begin
                if (ch_reg == n_ch)
                begin
                    ch_next = '0;
                    if (busy_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        run_after_next = 1'b0;
                        state_next     = ST_RA_RD;
                    end
                end
                else
                begin
                    rd_step    = (phase_reg[chi] == PH_ACTIVE) ? step_inc : step_reg[chi];
                    mem_rd     = 1'b1;
                    rd_ok_next = 32'(rd_step) < MAX_STEPS;
                    state_next = ST_EX;
                end
            end

            ST_EX:
            begin
                unique case (phase_reg[chi])
                    PH_ACTIVE:
                    begin
                        opnd = rd_ok_reg ? mem_q.delay : 16'd0;
                        if (fin_reg[3'(chi)] || (now_reg > end_reg[chi]))
                        begin
                            ch_we    = 1'b1;
                            step_new = step_inc;
                            if (step_inc >= len_reg[chi])
                            begin
                                ph_new   = PH_IDLE;
                                ctl.push = 1'b1;
                                ctl.kind = KIND_STOP;
                                ctl.chan = 3'(chi);
                            end
                            else
                            begin
                                ph_new = PH_WAITING;
                                act_we = 1'b1;
                            end
                        end
                    end
                    PH_WAITING:
                    begin
                        opnd = rd_ok_reg ? mem_q.duration : 16'd0;
                        if (now_reg > act_reg[chi])
                        begin
                            ch_we     = 1'b1;
                            ph_new    = PH_ACTIVE;
                            end_we    = 1'b1;
                            ctl.push  = 1'b1;
                            ctl.kind  = KIND_START;
                            ctl.chan  = 3'(chi);
                            ctl.instr = rd_ok_reg ? mem_q.code : 16'd0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if ((step_new < len_reg[chi]) || (ph_new != PH_IDLE))
                begin
                    busy_next = 1'b1;
                end
                ch_next    = ch_reg + (CW+1)'(1);
                state_next = ST_RD;
            end

            ST_STOP:
            begin
                if (ch_reg == n_ch)
                begin
                    ch_next    = '0;
                    state_next = ST_RA_RD;
                end
                else
                begin
                    ctl.push = 1'b1;
                    ctl.kind = KIND_STOP;
                    ctl.chan = 3'(chi);
                    ch_next  = ch_reg + (CW+1)'(1);
                end
            end

            ST_RA_RD:
            begin
                if (ch_reg == n_ch)
                begin
                    running_next = run_after_reg;
                    state_next   = ST_OUT;
                end
                else
                begin
                    rd_step    = '0;
                    mem_rd     = 1'b1;
                    rd_ok_next = 1'b1;
                    state_next = ST_RA_EX;
                end
            end

            ST_RA_EX:
            begin
                opnd       = mem_q.delay;
                ch_we      = 1'b1;
                step_new   = '0;
                ph_new     = PH_WAITING;
                act_we     = 1'b1;
                ch_next    = ch_reg + (CW+1)'(1);
                state_next = ST_RA_RD;
            end

            ST_OUT:
            begin
                ctl.close  = 1'b1;
                ctl.busy   = running_reg;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mem_raddr = AW'(32'(chi) * MAX_STEPS + 32'(rd_step));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            running_reg   <= 1'b0;
            run_after_reg <= 1'b0;
            busy_reg      <= 1'b0;
            rd_ok_reg     <= 1'b0;
            cfg_reg       <= CFG_W'(1);
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                phase_reg[i] <= PH_WAITING;
                step_reg[i]  <= '0;
                act_reg[i]   <= '0;
                end_reg[i]   <= '0;
                len_reg[i]   <= STEP_W'(1);
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            running_reg   <= running_next;
            run_after_reg <= run_after_next;
            busy_reg      <= busy_next;
            rd_ok_reg     <= rd_ok_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            if (ch_we)
            begin
                phase_reg[chi] <= ph_new;
                step_reg[chi]  <= step_new;
            end
            if (act_we)
            begin
                act_reg[chi] <= sum;
            end
            if (end_we)
            begin
                end_reg[chi] <= sum;
            end
            if (mem_wr && in_word.step_is_final)
            begin
                len_reg[in_word.load_channel[CW-1:0]] <= STEP_W'(in_word.load_step) + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= in_word.now_ms;
            fin_reg <= in_word.finished_mask;
        end
    end

    // an accepted word always keeps the input stalled on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input not stalled after accept");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.event_kind == KIND_STATUS) |-> out_word.last)
        else $error("status word without last");

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.last) |-> (out_word.event_kind == KIND_STATUS))
        else $error("last on an event word");

    a_close_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.close |=> (state_reg == ST_IDLE))
        else $error("sequencer not idle after close");

endmodule

@@ rtl/mcts_tl_mem.sv @@
`timescale 1ns / 1ps
// Timeline step memory: one write port, one registered read port.
// Depends on mcts_pkg for the entry type.
module mcts_tl_mem
    import mcts_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_CHANNELS * DEF_MAX_STEPS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  tl_entry_t       wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output tl_entry_t       rd_data
);

    tl_entry_t mem [DEPTH];
    tl_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/mcts_evq.sv @@
`timescale 1ns / 1ps
// Event buffer and output register: holds up to eight events of one input word,
// then drains them followed by the status word. Depends on mcts_pkg.
module mcts_evq
    import mcts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  evq_ctl_t  ctl,
    output logic      busy,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  chan;
        logic [15:0] instr;
    } ev_t;

    ev_t        buf_reg [8];
    logic [3:0] cnt_reg, cnt_next;
    logic [3:0] rd_reg, rd_next;
    logic       close_reg, close_next;
    logic       busy_bit_reg, busy_bit_next;
    logic       out_valid_reg, out_valid_next;
    out_word_t  out_reg, out_next;
    logic       load_out;

    assign load_out = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            buf_reg[cnt_reg[2:0]] <= '{kind: ctl.kind, chan: ctl.chan, instr: ctl.instr};
        end
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        rd_next        = rd_reg;
        close_next     = close_reg;
        busy_bit_next  = busy_bit_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (ctl.push)
        begin
            cnt_next = cnt_reg + 4'd1;
        end
        if (ctl.close)
        begin
            close_next    = 1'b1;
            busy_bit_next = ctl.busy;
        end
        if (close_reg && load_out)
        begin
            out_valid_next = 1'b1;
            if (rd_reg != cnt_reg)
            begin
                out_next.event_kind        = buf_reg[rd_reg[2:0]].kind;
                out_next.event_channel     = buf_reg[rd_reg[2:0]].chan;
                out_next.event_instruction = buf_reg[rd_reg[2:0]].instr;
                out_next.busy_res          = busy_bit_reg;
                out_next.last              = 1'b0;
                rd_next                    = rd_reg + 4'd1;
            end
            else
            begin
                out_next.event_kind        = KIND_STATUS;
                out_next.event_channel     = 3'd0;
                out_next.event_instruction = 16'd0;
                out_next.busy_res          = busy_bit_reg;
                out_next.last              = 1'b1;
                rd_next                    = 4'd0;
                cnt_next                   = 4'd0;
                close_next                 = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= 4'd0;
            rd_reg        <= 4'd0;
            close_reg     <= 1'b0;
            busy_bit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rd_reg        <= rd_next;
            close_reg     <= close_next;
            busy_bit_reg  <= busy_bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign busy      = close_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule
